### hw/rtl/greedy_conflict_free_move_select_assert.svh
// assertion macros for the move selector
// expects signals named clock and reset in the including module
`ifndef GREEDY_CONFLICT_FREE_MOVE_SELECT_ASSERT_SVH
`define GREEDY_CONFLICT_FREE_MOVE_SELECT_ASSERT_SVH

// same-cycle implication
`define GCFMS_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GCFMS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/gcfms_pkg.sv
// constants shared by the greedy move selector
// no dependencies
package gcfms_pkg;

   localparam int unsigned NODES = 1024;
   localparam int unsigned IDX_W = 10;

   localparam int unsigned CNT_W = 11;
   localparam int unsigned POS_W = 17;
   localparam logic [CNT_W-1:0] USED_MAX = 11'd2047;
   localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

   localparam int unsigned MAX_ITEMS_DEFAULT = 65536;

   // run tag kept in the mark memories
   localparam int unsigned EPOCH_W = 8;
   localparam logic [EPOCH_W-1:0] EPOCH_FIRST = 8'd1;
   localparam logic [EPOCH_W-1:0] EPOCH_MAX = 8'd255;

endpackage

### hw/rtl/greedy_conflict_free_move_select.sv
// greedy conflict-free move selector, top level; uses gcfms_pkg and the assert header
// an accepted move is registered in stage 1, then in the result register once rsp_stall allows
// throughput: one move per cycle unless req_stall; marks in three tagged memories, registered reads
// reset (synchronous): counters clear, then a clearing pass over all 1024 entries of the mark
//   memories with req_stall high; the same pass repeats after every 255th run, and req_stall
//   is also high while that run's last move waits in stage 1
`include "greedy_conflict_free_move_select_assert.svh"

module greedy_conflict_free_move_select #(
   parameter int unsigned MAX_ITEMS = gcfms_pkg::MAX_ITEMS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [gcfms_pkg::IDX_W-1:0]    req_node,
   input  logic [gcfms_pkg::IDX_W-1:0]    req_src_community,
   input  logic [gcfms_pkg::IDX_W-1:0]    req_dest_community,
   input  logic                           req_last_of_run,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic                           rsp_selected,
   output logic [gcfms_pkg::POS_W-1:0]    rsp_stop_position,
   output logic                           rsp_budget_exhausted,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [gcfms_pkg::CNT_W-1:0]    csr_node_count
);

   localparam int unsigned RW = $clog2(MAX_ITEMS + 1);
   localparam int unsigned SW = (RW > gcfms_pkg::POS_W) ? RW : gcfms_pkg::POS_W;
   localparam logic [RW-1:0] MAX_POS = RW'(MAX_ITEMS);
   localparam int unsigned IW = gcfms_pkg::IDX_W;
   localparam int unsigned EW = gcfms_pkg::EPOCH_W;
   localparam int unsigned CW = gcfms_pkg::CNT_W;

   // mark memories: an entry is marked when it holds the current run tag
   logic [EW-1:0] node_mem [gcfms_pkg::NODES];
   logic [EW-1:0] comm_a_mem [gcfms_pkg::NODES];   // written with source communities
   logic [EW-1:0] comm_b_mem [gcfms_pkg::NODES];   // written with destination communities

   logic          s1_valid_ff, s1_valid_in;
   logic [IW-1:0] s1_nd_ff, s1_sc_ff, s1_dc_ff;
   logic          s1_last_ff;
   logic [EW-1:0] nm_rd_ff, ca_s_rd_ff, ca_d_rd_ff, cb_s_rd_ff, cb_d_rd_ff;

   // write of the move ahead, landing on the same edge as this move's reads
   logic          byp_valid_ff, byp_valid_in;
   logic [IW-1:0] byp_nd_ff, byp_sc_ff, byp_dc_ff;

   logic [CW-1:0] used_ff, used_in;
   logic [RW-1:0] run_index_ff, run_index_in;
   logic [RW-1:0] last_stop_ff, last_stop_in;
   logic [EW-1:0] epoch_ff, epoch_in;
   logic          clear_busy_ff, clear_busy_in;
   logic [IW-1:0] clear_addr_ff, clear_addr_in;
   logic [CW-1:0] node_count_ff, node_count_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      rsp_selected_ff;
   logic [gcfms_pkg::POS_W-1:0] rsp_stop_ff;
   logic                      rsp_exhausted_ff;

   logic          req_accept, s1_adv, wrap_hold;
   logic          node_marked, src_marked, dest_marked, s1_sel;
   logic [RW-1:0] pos_next;
   logic [CW:0]   used_sum;
   logic [CW-1:0] used_new;
   logic [RW-1:0] last_stop_new, stop_c;
   logic [SW-1:0] stop_ext;
   logic          exhausted_c;

   // ---- handshake ----
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign wrap_hold  = s1_valid_ff && s1_last_ff && (epoch_ff == gcfms_pkg::EPOCH_MAX);
   assign req_stall  = clear_busy_ff || wrap_hold || (s1_valid_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // ---- decision ----
   always_comb begin
      node_marked = (nm_rd_ff == epoch_ff) || (byp_valid_ff && (byp_nd_ff == s1_nd_ff));
      src_marked  = (ca_s_rd_ff == epoch_ff) || (cb_s_rd_ff == epoch_ff) ||
                    (byp_valid_ff && ((byp_sc_ff == s1_sc_ff) || (byp_dc_ff == s1_sc_ff)));
      dest_marked = (ca_d_rd_ff == epoch_ff) || (cb_d_rd_ff == epoch_ff) ||
                    (byp_valid_ff && ((byp_sc_ff == s1_dc_ff) || (byp_dc_ff == s1_dc_ff)));
      s1_sel = (used_ff < node_count_ff) && !node_marked && !src_marked && !dest_marked;

      pos_next = (run_index_ff == MAX_POS) ? MAX_POS : run_index_ff + RW'(1);

      used_sum = {1'b0, used_ff} + (CW+1)'(2);
      if (!s1_sel) begin
         used_new = used_ff;
      end else if (used_sum > {1'b0, gcfms_pkg::USED_MAX}) begin
         used_new = gcfms_pkg::USED_MAX;
      end else begin
         used_new = used_sum[CW-1:0];
      end

      last_stop_new = s1_sel ? pos_next : last_stop_ff;
      exhausted_c   = used_new >= node_count_ff;
      // empty selection at run end reports the run length
      stop_c   = (s1_last_ff && (last_stop_new == '0)) ? pos_next : last_stop_new;
      stop_ext = SW'(stop_c);
   end

   // ---- next state ----
   always_comb begin
      s1_valid_in   = s1_valid_ff;
      byp_valid_in  = byp_valid_ff;
      used_in       = used_ff;
      run_index_in  = run_index_ff;
      last_stop_in  = last_stop_ff;
      epoch_in      = epoch_ff;
      clear_busy_in = clear_busy_ff;
      clear_addr_in = clear_addr_ff;
      node_count_in = node_count_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (s1_adv) begin
         rsp_valid_in = 1'b1;
         s1_valid_in  = 1'b0;
         if (s1_last_ff) begin
            used_in      = '0;
            run_index_in = '0;
            last_stop_in = '0;
            if (epoch_ff == gcfms_pkg::EPOCH_MAX) begin
               clear_busy_in = 1'b1;
               clear_addr_in = '0;
               epoch_in      = gcfms_pkg::EPOCH_FIRST;
            end else begin
               epoch_in = epoch_ff + EW'(1);
            end
         end else begin
            used_in      = used_new;
            last_stop_in = last_stop_new;
            if (run_index_ff != MAX_POS) begin
               run_index_in = run_index_ff + RW'(1);
            end
         end
      end
      if (req_accept) begin
         s1_valid_in  = 1'b1;
         byp_valid_in = s1_adv && s1_sel && !s1_last_ff;
      end
      if (clear_busy_ff) begin
         clear_addr_in = clear_addr_ff + IW'(1);
         if (clear_addr_ff == IW'(gcfms_pkg::NODES - 1)) begin
            clear_busy_in = 1'b0;
         end
      end
      if (csr_valid && csr_ready) begin
         node_count_in = csr_node_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         byp_valid_ff  <= 1'b0;
         used_ff       <= '0;
         run_index_ff  <= '0;
         last_stop_ff  <= '0;
         epoch_ff      <= gcfms_pkg::EPOCH_FIRST;
         clear_busy_ff <= 1'b1;
         clear_addr_ff <= '0;
         node_count_ff <= gcfms_pkg::NODE_COUNT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         byp_valid_ff  <= byp_valid_in;
         used_ff       <= used_in;
         run_index_ff  <= run_index_in;
         last_stop_ff  <= last_stop_in;
         epoch_ff      <= epoch_in;
         clear_busy_ff <= clear_busy_in;
         clear_addr_ff <= clear_addr_in;
         node_count_ff <= node_count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // ---- payload registers ----
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_nd_ff   <= req_node;
         s1_sc_ff   <= req_src_community;
         s1_dc_ff   <= req_dest_community;
         s1_last_ff <= req_last_of_run;
         byp_nd_ff  <= s1_nd_ff;
         byp_sc_ff  <= s1_sc_ff;
         byp_dc_ff  <= s1_dc_ff;
      end
      if (s1_adv) begin
         rsp_selected_ff  <= s1_sel;
         rsp_stop_ff      <= stop_ext[gcfms_pkg::POS_W-1:0];
         rsp_exhausted_ff <= exhausted_c;
      end
   end

   // ---- mark memories ----
   always_ff @(posedge clock) begin
      if (clear_busy_ff) begin
         node_mem[clear_addr_ff]   <= '0;
         comm_a_mem[clear_addr_ff] <= '0;
         comm_b_mem[clear_addr_ff] <= '0;
      end else if (s1_adv && s1_sel) begin
         node_mem[s1_nd_ff]   <= epoch_ff;
         comm_a_mem[s1_sc_ff] <= epoch_ff;
         comm_b_mem[s1_dc_ff] <= epoch_ff;
      end
      if (req_accept) begin
         nm_rd_ff   <= node_mem[req_node];
         ca_s_rd_ff <= comm_a_mem[req_src_community];
         ca_d_rd_ff <= comm_a_mem[req_dest_community];
         cb_s_rd_ff <= comm_b_mem[req_src_community];
         cb_d_rd_ff <= comm_b_mem[req_dest_community];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_selected         = rsp_selected_ff;
   assign rsp_stop_position    = rsp_stop_ff;
   assign rsp_budget_exhausted = rsp_exhausted_ff;

   // ---- assertions ----
   `GCFMS_ASSERT_NOW(a_clear_restarts_tag, $fell(clear_busy_ff),
      epoch_ff == gcfms_pkg::EPOCH_FIRST, "tag not restarted after clearing pass")
   `GCFMS_ASSERT_NEXT(a_run_end_clears, s1_adv && s1_last_ff,
      (run_index_ff == '0) && (used_ff == '0) && (last_stop_ff == '0),
      "run state not cleared after last move")
   `GCFMS_ASSERT_NEXT(a_no_repeat_node, s1_adv && s1_sel && !s1_last_ff,
      !(s1_valid_ff && s1_sel && (s1_nd_ff == $past(s1_nd_ff))),
      "node selected twice in a run")

endmodule

### tb/selection_board_pkg.sv
// move and pick types plus the expected-pick tracker for the move selector bench
// depends on gcfms_pkg for widths, node count and reset values
package selection_board_pkg;

   localparam int unsigned NODES            = gcfms_pkg::NODES;
   localparam int unsigned IDX_W            = gcfms_pkg::IDX_W;
   localparam int unsigned CNT_W            = gcfms_pkg::CNT_W;
   localparam int unsigned POS_W            = gcfms_pkg::POS_W;
   localparam int unsigned USED_MAX         = gcfms_pkg::USED_MAX;
   localparam int unsigned NODE_COUNT_RESET = gcfms_pkg::NODE_COUNT_RESET;
   localparam int unsigned RUN_LIMIT        = gcfms_pkg::MAX_ITEMS_DEFAULT;

   typedef struct packed {
      logic [IDX_W-1:0] node;
      logic [IDX_W-1:0] src_community;
      logic [IDX_W-1:0] dest_community;
      logic             last_of_run;
   } move_type;

   typedef struct packed {
      logic             selected;
      logic [POS_W-1:0] stop_position;
      logic             budget_exhausted;
   } pick_type;

   class selection_board;
      logic [NODES-1:0] node_taken;
      logic [NODES-1:0] community_taken;
      int unsigned      used_count;
      int unsigned      run_pos;
      int unsigned      last_stop;
      int unsigned      node_count;
      pick_type         expected_picks[$];
      int               errors;
      int               moves_seen;
      int               picks_checked;
      int               runs_seen;
      int               selected_seen;
      int               exhausted_seen;

      function new();
         clear_run();
         node_count = NODE_COUNT_RESET;
         errors = 0;
         moves_seen = 0;
         picks_checked = 0;
         runs_seen = 0;
         selected_seen = 0;
         exhausted_seen = 0;
      endfunction

      function void clear_run();
         node_taken = '0;
         community_taken = '0;
         used_count = 0;
         run_pos = 0;
         last_stop = 0;
      endfunction

      function void set_node_count(logic [CNT_W-1:0] value);
         node_count = value;
      endfunction

      function pick_type predict_pick(move_type m);
         pick_type    p;
         int unsigned nd;
         int unsigned sc;
         int unsigned dc;
         int unsigned pos_next;
         int unsigned stop;
         nd = m.node % NODES;
         sc = m.src_community % NODES;
         dc = m.dest_community % NODES;
         pos_next = (run_pos + 1 > RUN_LIMIT) ? RUN_LIMIT : run_pos + 1;
         p.selected = 1'b0;
         if (used_count < node_count && !node_taken[nd] && !community_taken[sc] &&
             !community_taken[dc]) begin
            p.selected = 1'b1;
            node_taken[nd] = 1'b1;
            community_taken[sc] = 1'b1;
            community_taken[dc] = 1'b1;
            used_count = used_count + 2;
            if (used_count > USED_MAX) used_count = USED_MAX;
            last_stop = pos_next;
         end
         p.budget_exhausted = (used_count >= node_count);
         // a run that ends with nothing picked reports its own length
         stop = (m.last_of_run && last_stop == 0) ? pos_next : last_stop;
         p.stop_position = POS_W'(stop);
         if (run_pos < RUN_LIMIT) run_pos++;
         if (m.last_of_run) begin
            clear_run();
            runs_seen++;
         end
         return p;
      endfunction

      function void note_move(move_type m);
         pick_type p;
         p = predict_pick(m);
         expected_picks.push_back(p);
         moves_seen++;
         if (p.selected) selected_seen++;
         if (p.budget_exhausted) exhausted_seen++;
      endfunction

      function int pending();
         return expected_picks.size();
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch at pick %0d: %s", picks_checked, msg);
      endtask

      task check_pick(pick_type got);
         pick_type want;
         if (expected_picks.size() == 0) begin
            report($sformatf("result with no move waiting (sel %0b stop %0d exh %0b)",
                             got.selected, got.stop_position, got.budget_exhausted));
            return;
         end
         want = expected_picks.pop_front();
         picks_checked++;
         if (got.selected !== want.selected)
            report($sformatf("selected %0b, want %0b", got.selected, want.selected));
         if (got.stop_position !== want.stop_position)
            report($sformatf("stop_position %0d, want %0d", got.stop_position,
                             want.stop_position));
         if (got.budget_exhausted !== want.budget_exhausted)
            report($sformatf("budget_exhausted %0b, want %0b", got.budget_exhausted,
                             want.budget_exhausted));
      endtask
   endclass

endpackage

### tb/tb.sv
// top-level bench for greedy_conflict_free_move_select: drives move runs and node_count writes,
// checks every pick against selection_board; depends on gcfms_pkg and selection_board_pkg
module tb;

   localparam int unsigned NODES            = gcfms_pkg::NODES;
   localparam int unsigned IDX_W            = gcfms_pkg::IDX_W;
   localparam int unsigned CNT_W            = gcfms_pkg::CNT_W;
   localparam int unsigned POS_W            = gcfms_pkg::POS_W;
   localparam int unsigned USED_MAX         = gcfms_pkg::USED_MAX;
   localparam int unsigned NODE_COUNT_RESET = gcfms_pkg::NODE_COUNT_RESET;

   localparam int CYCLE_LIMIT = 400000;
   localparam int HOLD_CYCLES = 200;
   localparam int MOVE_TARGET = 630;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   logic [IDX_W-1:0] req_node;
   logic [IDX_W-1:0] req_src_community;
   logic [IDX_W-1:0] req_dest_community;
   logic             req_last_of_run;
   logic             rsp_valid;
   logic             rsp_stall;
   logic             rsp_selected;
   logic [POS_W-1:0] rsp_stop_position;
   logic             rsp_budget_exhausted;
   logic             csr_valid;
   logic             csr_ready;
   logic [CNT_W-1:0] csr_node_count;

   selection_board_pkg::selection_board board;
   int               send_mode;
   int               recv_mode;
   int               hold_asked;
   int unsigned      cycles = 0;
   int               settings_used;

   greedy_conflict_free_move_select dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_node            (req_node),
      .req_src_community   (req_src_community),
      .req_dest_community  (req_dest_community),
      .req_last_of_run     (req_last_of_run),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_selected        (rsp_selected),
      .rsp_stop_position   (rsp_stop_position),
      .rsp_budget_exhausted(rsp_budget_exhausted),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_node_count      (csr_node_count)
   );

   initial clock = 1'b0;
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // mode 0: never idle, 1: light, 2: heavy; a few long pauses in either idling mode
   function automatic int pick_pause(int mode);
      int r;
      r = $urandom_range(0, 99);
      if (mode == 0 || r < (mode == 1 ? 70 : 40)) return 0;
      if (r < (mode == 1 ? 95 : 85)) return $urandom_range(1, 4);
      return $urandom_range(10, 40);
   endfunction

   function automatic int pick_run_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 1;
      if (r < 85) return $urandom_range(2, 4);
      if (r < 97) return $urandom_range(5, 20);
      return $urandom_range(21, 80);
   endfunction

   // narrow windows make marks collide; extremes and full range keep every bit moving
   function automatic logic [IDX_W-1:0] pick_index(int mode, int unsigned base,
                                                   int unsigned span);
      int r;
      r = $urandom_range(0, 9);
      if (mode == 1 || (mode == 2 && r > 5)) return IDX_W'($urandom_range(0, NODES - 1));
      if (mode == 2 && r < 3) return (r == 0) ? {IDX_W{1'b0}} : {IDX_W{1'b1}};
      return IDX_W'(base + $urandom_range(0, span));
   endfunction

   // receiver side: random stall, or a long hold-off on request
   initial begin
      int stall_left;
      int hold_done;
      stall_left = 0;
      hold_done = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_done != hold_asked) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_done++;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_pause(recv_mode);
         end
      end
   end

   always @(posedge clock) begin
      selection_board_pkg::pick_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.selected = rsp_selected;
         got.stop_position = rsp_stop_position;
         got.budget_exhausted = rsp_budget_exhausted;
         board.check_pick(got);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timed out after %0d cycles with %0d picks outstanding", cycles,
                  board.pending());
         $display("FAILURE");
         $finish;
      end
   end

   task automatic sender_idle();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   // valid stays up after a transfer; the next call either replaces the payload or drops it
   task automatic send_move(input selection_board_pkg::move_type m);
      int gap;
      gap = pick_pause(send_mode);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_node <= m.node;
      req_src_community <= m.src_community;
      req_dest_community <= m.dest_community;
      req_last_of_run <= m.last_of_run;
      do @(posedge clock); while (req_stall);
      board.note_move(m);
   endtask

   task automatic send_fields(input int unsigned n, input int unsigned s, input int unsigned d,
                              input bit last);
      selection_board_pkg::move_type m;
      m.node = IDX_W'(n);
      m.src_community = IDX_W'(s);
      m.dest_community = IDX_W'(d);
      m.last_of_run = last;
      send_move(m);
   endtask

   task automatic send_random_run(input int len);
      selection_board_pkg::move_type m;
      int          mode;
      int unsigned base;
      int unsigned span;
      int          i;
      mode = $urandom_range(0, 2);
      span = (1 << $urandom_range(1, 5)) - 1;
      base = ($urandom_range(0, 3) == 0) ? NODES - 1 - span : $urandom_range(0, NODES - 1);
      for (i = 0; i < len; i++) begin
         m.node = pick_index(mode, base, span);
         m.src_community = pick_index(mode, base, span);
         m.dest_community = ($urandom_range(0, 9) == 0) ? m.src_community :
                            pick_index(mode, base, span);
         m.last_of_run = (i == len - 1);
         send_move(m);
      end
   endtask

   task automatic wait_drained();
      sender_idle();
      while (board.pending() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [CNT_W-1:0] value);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_node_count <= value;
      do @(posedge clock); while (!csr_ready);
      board.set_node_count(value);
      @(negedge clock);
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   initial begin
      int phase;
      int nc;
      int k;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_node = '0;
      req_src_community = '0;
      req_dest_community = '0;
      req_last_of_run = 1'b0;
      csr_valid = 1'b0;
      csr_node_count = '0;
      send_mode = 1;
      recv_mode = 1;
      hold_asked = 0;
      settings_used = 0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // reset node_count: same src/dest, extremes, node and community conflicts
      send_fields(0, 0, 0, 0);
      send_fields(1023, 1023, 1023, 0);
      send_fields(0, 5, 6, 0);
      send_fields(5, 0, 7, 0);
      send_fields(6, 8, 1023, 0);
      send_fields(1, 2, 3, 1);
      send_fields(7, 7, 8, 1);
      send_fields(10'h2AA, 10'h155, 10'h3FF, 0);
      send_fields(10'h155, 10'h2AA, 10'h000, 1);
      // zero budget: nothing picked, run end reports the run length
      write_node_count(0);
      send_fields(3, 4, 5, 0);
      send_fields(3, 4, 5, 1);
      send_fields(9, 9, 9, 1);
      // budget of one runs out after the first pick
      write_node_count(1);
      send_fields(1, 2, 3, 0);
      send_fields(4, 5, 6, 1);

      phase = 0;
      while (board.moves_seen < MOVE_TARGET) begin
         case (phase % 8)
            0: nc = 0;
            1: nc = 1;
            2: nc = USED_MAX;
            3: nc = $urandom_range(2, 8);
            4: nc = NODE_COUNT_RESET;
            5: nc = $urandom_range(1, USED_MAX);
            6: nc = 3;
            default: nc = $urandom_range(9, 64);
         endcase
         write_node_count(CNT_W'(nc));
         send_mode = $urandom_range(0, 2);
         recv_mode = $urandom_range(0, 2);
         for (k = 0; k < 20 && board.moves_seen < MOVE_TARGET; k++) begin
            if (phase == 3 && k == 5) begin
               // receiver holds off while moves keep coming, so the input backs up
               send_mode = 0;
               hold_asked++;
               send_random_run(40);
               send_mode = 1;
            end
            if (phase == 3 && k == 10) wait_drained();
            send_random_run(pick_run_length());
         end
         phase++;
      end

      sender_idle();
      k = 0;
      while (board.pending() > 0 && k < 20000) begin
         @(posedge clock);
         k++;
      end
      repeat (8) @(posedge clock);
      if (board.pending() > 0)
         board.report($sformatf("%0d expected picks never arrived", board.pending()));
      $display("covered %0d moves in %0d runs over %0d node_count settings",
               board.moves_seen, board.runs_seen, settings_used);
      $display("%0d moves picked, %0d picks with budget exhausted, %0d mismatches",
               board.selected_seen, board.exhausted_seen, board.errors);
      if (board.errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
